// ===== rtl/core/lgsms_pkg.sv =====
// ----------------------------------------------------------------------------
// lgsms_pkg
// Shared types, codes and reset values of the swing motor sequencer.
// ----------------------------------------------------------------------------
package lgsms_pkg;

  localparam int unsigned TimerWidth  = 14;
  localparam int unsigned RegWidth    = 14;
  localparam int unsigned FieldWidth  = 14;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CmpWidth    = (TimerWidth > RegWidth) ? TimerWidth : RegWidth;

  // Drive codes
  localparam logic [1:0] DrvStop = 2'd0;
  localparam logic [1:0] DrvCw   = 2'd1;
  localparam logic [1:0] DrvCcw  = 2'd2;

  // Command codes (pitch: up/down, swing: left/right, spray: jet/spray)
  localparam logic [1:0] CmdFirst  = 2'd1;
  localparam logic [1:0] CmdSecond = 2'd2;

  // Swing modes
  localparam logic [2:0] ModeManual = 3'd0;
  localparam logic [2:0] ModeOne    = 3'd1;
  localparam logic [2:0] ModeTwo    = 3'd2;
  localparam logic [2:0] ModeThree  = 3'd3;
  localparam logic [2:0] ModeFour   = 3'd4;

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] RegCentreReturn = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegStrokeOne    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegStrokeTwo    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegStrokeThree  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegStrokeFour   = 3'd4;

  // Register reset values
  localparam logic [RegWidth-1:0] CentreReturnReset = 14'd2500;
  localparam logic [RegWidth-1:0] StrokeOneReset    = 14'd4000;
  localparam logic [RegWidth-1:0] StrokeTwoReset    = 14'd6000;
  localparam logic [RegWidth-1:0] StrokeThreeReset  = 14'd8000;
  localparam logic [RegWidth-1:0] StrokeFourReset   = 14'd10000;

  typedef struct packed {
    logic       centred;
    logic [2:0] auto_mode;
    logic [1:0] spray_command;
    logic [1:0] swing_command;
    logic [1:0] pitch_command;
    logic       limit_right;
    logic       limit_left;
    logic       limit_down;
    logic       limit_up;
    logic       run_enabled;
  } item_t;

  typedef struct packed {
    logic [RegWidth-1:0] centre_return_ticks;
    logic [RegWidth-1:0] stroke_mode_one;
    logic [RegWidth-1:0] stroke_mode_two;
    logic [RegWidth-1:0] stroke_mode_three;
    logic [RegWidth-1:0] stroke_mode_four;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            pitch_drive;
    logic [1:0]            swing_drive;
    logic [1:0]            spray_drive;
    logic [TimerWidth-1:0] timer;
  } step_t;

endpackage

// ===== rtl/core/lgsms_step.sv =====
// ----------------------------------------------------------------------------
// lgsms_step
// Decision logic for one tick: drives and the next swing timer value.
// ----------------------------------------------------------------------------
module lgsms_step import lgsms_pkg::*; (
  input  item_t                 item_i,
  input  cfg_t                  cfg_i,
  input  logic [1:0]            hold_i,
  input  logic [TimerWidth-1:0] timer_i,
  output step_t                 step_o
);

  logic [RegWidth-1:0]   stroke;
  logic [RegWidth+1:0]   triple;
  logic [RegWidth-1:0]   hi_thresh;
  logic [RegWidth-1:0]   lo_thresh;
  logic [1:0]            pitch;
  logic [1:0]            swing;
  logic [1:0]            spray;
  logic [TimerWidth-1:0] timer;

  always_comb begin
    case (item_i.auto_mode)
      ModeOne:   stroke = cfg_i.stroke_mode_one;
      ModeTwo:   stroke = cfg_i.stroke_mode_two;
      ModeThree: stroke = cfg_i.stroke_mode_three;
      default:   stroke = cfg_i.stroke_mode_four;
    endcase
  end

  // Three quarters and one quarter of the stroke, rounded down.
  assign triple    = {2'b00, stroke} + {1'b0, stroke, 1'b0};
  assign hi_thresh = triple[RegWidth+1:2];
  assign lo_thresh = {2'b00, stroke[RegWidth-1:2]};

  always_comb begin
    pitch = DrvStop;
    spray = DrvStop;
    swing = hold_i;
    timer = timer_i;
    if (item_i.run_enabled) begin
      if (item_i.pitch_command == CmdFirst && !item_i.limit_up) begin
        pitch = DrvCw;
      end else if (item_i.pitch_command == CmdSecond && !item_i.limit_down) begin
        pitch = DrvCcw;
      end

      if (item_i.auto_mode == ModeManual) begin
        // Manual swing runs with the motor direction inverted.
        if (item_i.swing_command == CmdFirst && !item_i.limit_left) begin
          swing = DrvCcw;
        end else if (item_i.swing_command == CmdSecond && !item_i.limit_right) begin
          swing = DrvCw;
        end else begin
          swing = DrvStop;
        end
      end else if (item_i.auto_mode inside {[ModeOne:ModeFour]}) begin
        if (!item_i.centred) begin
          if (item_i.limit_left) begin
            swing = DrvCw;
            timer = TimerWidth'(cfg_i.centre_return_ticks);
          end else if (timer_i == '0) begin
            swing = DrvCcw;
          end
        end else begin
          if (timer_i == '0) begin
            timer = TimerWidth'(stroke);
          end
          if (CmpWidth'(timer) >= CmpWidth'(hi_thresh) && !item_i.limit_left) begin
            swing = DrvCcw;
          end else if (CmpWidth'(timer) >= CmpWidth'(lo_thresh) && !item_i.limit_right) begin
            swing = DrvCw;
          end else if (timer != '0 && !item_i.limit_left) begin
            swing = DrvCcw;
          end else begin
            swing = DrvStop;
          end
        end
      end

      if (item_i.spray_command == CmdFirst) begin
        spray = DrvCw;
      end else if (item_i.spray_command == CmdSecond) begin
        spray = DrvCcw;
      end
    end else begin
      swing = DrvStop;
    end

    // The timer counts one tick down after the decision and stops at zero.
    if (timer != '0) begin
      timer = timer - TimerWidth'(1);
    end
  end

  assign step_o.pitch_drive = pitch;
  assign step_o.swing_drive = swing;
  assign step_o.spray_drive = spray;
  assign step_o.timer       = timer;

endmodule

// ===== rtl/core/limit_gated_swing_motor_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// limit_gated_swing_motor_sequencer_core
// Tick-driven pitch, swing and spray motor sequencer with limit gating.
// ----------------------------------------------------------------------------
// Each input beat is one tick and yields exactly one output beat. The
// block takes one tick per clock cycle while the receiver does not hold off
// results. An accepted beat waits in the input register and moves into the
// result register when that register is free or being emptied; the decision
// logic and the swing state update sit between the two registers. The input
// stalls only while both registers are full and the receiver holds off the
// result beat.
// Configuration writes are always taken and should only be issued while no
// tick is in flight. There is no memory and no start-up clearing pass.
module limit_gated_swing_motor_sequencer_core import lgsms_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  // [0] run_enabled, [1] limit_up, [2] limit_down, [3] limit_left,
  // [4] limit_right, [6:5] pitch_command, [8:7] swing_command,
  // [10:9] spray_command, [13:11] auto_mode, [14] centred, [15] zero
  input  logic [15:0]            s_tdata_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  // [1:0] pitch_drive, [3:2] swing_drive, [5:4] spray_drive,
  // [19:6] timer_value, [23:20] zero
  output logic [23:0]            m_tdata_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [RegWidth-1:0]    cfg_data_i
);

  cfg_t                  cfg_q;
  item_t                 item_q;
  logic                  in_valid_q;
  step_t                 step;
  logic [1:0]            hold_q;
  logic [TimerWidth-1:0] timer_q;
  logic                  out_valid_q;
  logic [5:0]            drives_q;
  logic [FieldWidth-1:0] timer_out_q;
  logic                  advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.centre_return_ticks <= CentreReturnReset;
      cfg_q.stroke_mode_one     <= StrokeOneReset;
      cfg_q.stroke_mode_two     <= StrokeTwoReset;
      cfg_q.stroke_mode_three   <= StrokeThreeReset;
      cfg_q.stroke_mode_four    <= StrokeFourReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCentreReturn: cfg_q.centre_return_ticks <= cfg_data_i;
        RegStrokeOne:    cfg_q.stroke_mode_one     <= cfg_data_i;
        RegStrokeTwo:    cfg_q.stroke_mode_two     <= cfg_data_i;
        RegStrokeThree:  cfg_q.stroke_mode_three   <= cfg_data_i;
        RegStrokeFour:   cfg_q.stroke_mode_four    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the result register is free or
  // being emptied in the same cycle.
  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      item_q <= item_t'(s_tdata_i[14:0]);
    end
  end

  lgsms_step u_step (
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .hold_i  (hold_q),
    .timer_i (timer_q),
    .step_o  (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= DrvStop;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        hold_q  <= step.swing_drive;
        timer_q <= step.timer;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drives_q    <= {step.spray_drive, step.swing_drive, step.pitch_drive};
      timer_out_q <= FieldWidth'(step.timer);
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0000, timer_out_q, drives_q};

  // An emergency stop tick leaves every drive stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !item_q.run_enabled |=> m_tdata_o[5:0] == 6'd0)
    else $error("drive active on an emergency stop tick");

  // The held swing state matches the pending swing drive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[3:2] == hold_q)
    else $error("swing hold differs from the pending swing drive");

  // The pending timer value is the timer state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[19:6] == FieldWidth'(timer_q))
    else $error("pending timer value differs from the timer state");

  // Input stalls only behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !s_tready_o |-> m_tvalid_o && !m_tready_i)
    else $error("input stalled while the result side was free");

  // No drive ever carries the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[1:0] != 2'd3 && m_tdata_o[3:2] != 2'd3
                   && m_tdata_o[5:4] != 2'd3)
    else $error("invalid drive code on the output");

endmodule
